@@ rtl/tat_pkg.sv @@
package tat_pkg;

  // Field widths of the item and result channels
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned TTL_W     = 16;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned REMOVED_W = 5;

  // Defaults
  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam logic [TTL_W-1:0] TTL_RESET  = TTL_W'(20);

  // Item modes
  typedef enum logic [MODE_W-1:0] {
    MODE_UPDATE = 2'd0,
    MODE_DETECT = 2'd1,
    MODE_AGE    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT       = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_DONE      = 3'd4
  } status_t;

  // One table entry as held in memory
  typedef struct packed {
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic [TTL_W-1:0]  ttl;
  } entry_t;

endpackage

@@ rtl/tat_ifs.sv @@
interface tat_in_if;
  logic                         valid;
  logic                         ready;
  logic [tat_pkg::MODE_W-1:0]   mode;
  logic [tat_pkg::ADDR_W-1:0]   addr_high;
  logic [tat_pkg::ADDR_W-1:0]   addr_low;
  logic [tat_pkg::TTL_W-1:0]    elapsed;

  modport source (output valid, output mode, output addr_high, output addr_low,
                  output elapsed, input ready);
  modport sink   (input valid, input mode, input addr_high, input addr_low,
                  input elapsed, output ready);
endinterface

interface tat_out_if;
  logic                          valid;
  logic                          ready;
  logic [tat_pkg::STATUS_W-1:0]  status;
  logic [tat_pkg::SLOT_W-1:0]    slot;
  logic [tat_pkg::TTL_W-1:0]     ttl_left;
  logic [tat_pkg::REMOVED_W-1:0] removed_count;

  modport source (output valid, output status, output slot, output ttl_left,
                  output removed_count, input ready);
  modport sink   (input valid, input status, input slot, input ttl_left,
                  input removed_count, output ready);
endinterface

interface tat_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tat_pkg::TTL_W-1:0]  ttl_reload;

  modport source (output valid, output ttl_reload, input ready);
  modport sink   (input valid, input ttl_reload, output ready);
endinterface

@@ rtl/tat_mem.sv @@
module tat_mem #(
  parameter int unsigned TABLE_DEPTH = tat_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  tat_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output tat_pkg::entry_t rd_data
);

  tat_pkg::entry_t mem [TABLE_DEPTH];
  tat_pkg::entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/tat_ctrl.sv @@
module tat_ctrl #(
  parameter int unsigned TABLE_DEPTH = tat_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  tat_in_if.sink                    in_ch,
  tat_out_if.source                 out_ch,
  input  logic [tat_pkg::TTL_W-1:0] ttl_reload,
  output logic                      mem_rd_en,
  output logic [IDX_W-1:0]          mem_rd_addr,
  input  tat_pkg::entry_t           mem_rd_data,
  output logic                      mem_wr_en,
  output logic [IDX_W-1:0]          mem_wr_addr,
  output tat_pkg::entry_t           mem_wr_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CLR,
    S_FIN
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t                        state_r;
  logic [TABLE_DEPTH-1:0]        valid_r;
  tat_pkg::mode_t                mode_r;
  logic [tat_pkg::ADDR_W-1:0]    hi_r;
  logic [tat_pkg::ADDR_W-1:0]    lo_r;
  logic [tat_pkg::TTL_W-1:0]     elapsed_r;
  logic [CNT_W-1:0]              ptr_r;
  logic                          chk_v_r;
  logic [IDX_W-1:0]              chk_idx_r;
  logic                          free_found_r;
  logic [IDX_W-1:0]              free_idx_r;
  logic [CNT_W-1:0]              removed_r;
  tat_pkg::status_t              res_status_r;
  logic [IDX_W-1:0]              res_slot_r;
  logic [tat_pkg::TTL_W-1:0]     res_ttl_r;
  logic                          out_valid_r;
  logic [tat_pkg::STATUS_W-1:0]  out_status_r;
  logic [tat_pkg::SLOT_W-1:0]    out_slot_r;
  logic [tat_pkg::TTL_W-1:0]     out_ttl_r;
  logic [tat_pkg::REMOVED_W-1:0] out_removed_r;

  logic             issue;
  logic             last_chk;
  logic             ent_valid;
  logic             addr_match;
  logic             free_here;
  logic             ins_found;
  logic [IDX_W-1:0] ins_idx;
  logic             age_keep;
  logic [IDX_W-1:0] ptr_idx;

  // Entry checks on the data read back last cycle
  assign ptr_idx    = ptr_r[IDX_W-1:0];
  assign issue      = (state_r == S_SCAN) && (ptr_r < CNT_W'(TABLE_DEPTH));
  assign last_chk   = (chk_idx_r == LAST_IDX);
  assign ent_valid  = valid_r[chk_idx_r];
  assign addr_match = ent_valid && (mem_rd_data.addr_high == hi_r)
                      && (mem_rd_data.addr_low == lo_r);
  assign free_here  = !ent_valid;
  assign ins_found  = free_found_r || free_here;
  assign ins_idx    = free_found_r ? free_idx_r : chk_idx_r;
  assign age_keep   = (mem_rd_data.ttl > elapsed_r);

  // Memory read: one entry per cycle during the sweep
  assign mem_rd_en   = issue;
  assign mem_rd_addr = ptr_idx;

  // Memory write-back: refresh, insert or aged TTL
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = chk_idx_r;
    mem_wr_data = '{addr_high: hi_r, addr_low: lo_r, ttl: ttl_reload};
    if ((state_r == S_SCAN) && chk_v_r) begin
      unique case (mode_r)
        tat_pkg::MODE_UPDATE: begin
          if (addr_match) begin
            mem_wr_en = 1'b1;
          end else if (last_chk && ins_found) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ins_idx;
          end
        end
        tat_pkg::MODE_AGE: begin
          if (ent_valid && age_keep) begin
            mem_wr_en   = 1'b1;
            mem_wr_data = '{addr_high: mem_rd_data.addr_high,
                            addr_low:  mem_rd_data.addr_low,
                            ttl:       mem_rd_data.ttl - elapsed_r};
          end
        end
        tat_pkg::MODE_DETECT, tat_pkg::MODE_CLEAR: begin
        end
      endcase
    end
  end

  // Sequencer, valid bits and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a finished result, or drop the one just taken
      if ((state_r == S_FIN) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode_r       <= tat_pkg::mode_t'(in_ch.mode);
            hi_r         <= in_ch.addr_high;
            lo_r         <= in_ch.addr_low;
            elapsed_r    <= in_ch.elapsed;
            ptr_r        <= '0;
            chk_v_r      <= 1'b0;
            free_found_r <= 1'b0;
            removed_r    <= '0;
            state_r      <= (tat_pkg::mode_t'(in_ch.mode) == tat_pkg::MODE_CLEAR)
                            ? S_CLR : S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            ptr_r <= ptr_r + CNT_W'(1);
          end
          chk_v_r   <= issue;
          chk_idx_r <= ptr_idx;
          if (chk_v_r) begin
            unique case (mode_r)
              tat_pkg::MODE_UPDATE, tat_pkg::MODE_DETECT: begin
                if (addr_match) begin
                  res_status_r <= tat_pkg::ST_HIT;
                  res_slot_r   <= chk_idx_r;
                  res_ttl_r    <= (mode_r == tat_pkg::MODE_UPDATE)
                                  ? ttl_reload : mem_rd_data.ttl;
                  state_r      <= S_FIN;
                end else begin
                  if (free_here && !free_found_r) begin
                    free_found_r <= 1'b1;
                    free_idx_r   <= chk_idx_r;
                  end
                  if (last_chk) begin
                    state_r    <= S_FIN;
                    res_slot_r <= '0;
                    res_ttl_r  <= '0;
                    if (mode_r == tat_pkg::MODE_DETECT) begin
                      res_status_r <= tat_pkg::ST_NOT_FOUND;
                    end else if (ins_found) begin
                      res_status_r     <= tat_pkg::ST_INSERTED;
                      res_slot_r       <= ins_idx;
                      res_ttl_r        <= ttl_reload;
                      valid_r[ins_idx] <= 1'b1;
                    end else begin
                      res_status_r <= tat_pkg::ST_FULL;
                    end
                  end
                end
              end
              tat_pkg::MODE_AGE: begin
                if (ent_valid && !age_keep) begin
                  valid_r[chk_idx_r] <= 1'b0;
                  removed_r          <= removed_r + CNT_W'(1);
                end
                if (last_chk) begin
                  state_r      <= S_FIN;
                  res_status_r <= tat_pkg::ST_DONE;
                  res_slot_r   <= '0;
                  res_ttl_r    <= '0;
                end
              end
              tat_pkg::MODE_CLEAR: begin
              end
            endcase
          end
        end
        S_CLR: begin
          // Walk the valid bits, counting the live entries dropped
          if (valid_r[ptr_idx]) begin
            valid_r[ptr_idx] <= 1'b0;
            removed_r        <= removed_r + CNT_W'(1);
          end
          ptr_r <= ptr_r + CNT_W'(1);
          if (ptr_idx == LAST_IDX) begin
            state_r      <= S_FIN;
            res_status_r <= tat_pkg::ST_DONE;
            res_slot_r   <= '0;
            res_ttl_r    <= '0;
          end
        end
        S_FIN: begin
          // Hand the result over once the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_status_r  <= res_status_r;
            out_slot_r    <= tat_pkg::SLOT_W'(res_slot_r);
            out_ttl_r     <= res_ttl_r;
            out_removed_r <= tat_pkg::REMOVED_W'(removed_r);
            state_r       <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.slot          = out_slot_r;
  assign out_ch.ttl_left      = out_ttl_r;
  assign out_ch.removed_count = out_removed_r;

`ifndef SYNTHESIS
  // A hit or an insert always names a live entry
  a_res_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && ((res_status_r == tat_pkg::ST_HIT) ||
                            (res_status_r == tat_pkg::ST_INSERTED)))
    |-> valid_r[res_slot_r])
    else $error("result slot is not a valid entry");

  // A finished clear leaves the table empty
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && (mode_r == tat_pkg::MODE_CLEAR)) |-> (valid_r == '0))
    else $error("table not empty after clear");

  // Memory writes only happen during a sweep
  a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r == S_SCAN))
    else $error("memory write outside a sweep");

  // The freed count never exceeds the table size
  a_removed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (removed_r <= CNT_W'(TABLE_DEPTH)))
    else $error("removed count exceeds table depth");

  // An insert adds exactly one valid entry
  a_insert_one: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && chk_v_r && (mode_r == tat_pkg::MODE_UPDATE) &&
     !addr_match && last_chk && ins_found)
    |=> ($countones(valid_r) == $countones($past(valid_r)) + 1))
    else $error("insert did not add exactly one entry");
`endif

endmodule

@@ rtl/ttl_aged_address_table_unit.sv @@
// Table of TABLE_DEPTH 128-bit relay addresses, each with a time-to-live.
// Each input transfer carries a mode: update (refresh on hit, else insert
// into the lowest free slot or report full), detect (lookup only), age
// (subtract elapsed from every live TTL, dropping entries whose TTL is not
// above it) or clear (drop all). Every item gives exactly one result.
// Addresses and TTLs live in a single-port-write, registered-read memory
// swept one entry per cycle; valid bits sit in flops cleared by reset.
// Update, detect and age read one memory entry per step, check it on the
// registered read data and then hand the result over (a hit ends the
// sweep early); clear walks the valid bits instead of the memory.
// A new item is taken while the previous result still waits in the output
// register. ttl_reload (reset 20) is written through the cfg channel.
module ttl_aged_address_table_unit #(
  parameter int unsigned TABLE_DEPTH = tat_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tat_in_if.sink     in_chan,
  tat_out_if.source  out_chan,
  tat_cfg_if.sink    cfg_chan
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [tat_pkg::TTL_W-1:0] ttl_reload_r;
  logic                      mem_rd_en;
  logic [IDX_W-1:0]          mem_rd_addr;
  tat_pkg::entry_t           mem_rd_data;
  logic                      mem_wr_en;
  logic [IDX_W-1:0]          mem_wr_addr;
  tat_pkg::entry_t           mem_wr_data;

  // Reload value register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_reload_r <= tat_pkg::TTL_RESET;
    end else if (cfg_chan.valid) begin
      ttl_reload_r <= cfg_chan.ttl_reload;
    end
  end

  assign cfg_chan.ready = 1'b1;

  tat_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_chan),
    .out_ch      (out_chan),
    .ttl_reload  (ttl_reload_r),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  tat_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
